>>> rtl/core/rpv_pkg.sv
package rpv_pkg;

  // Byte codes that the path rules single out.
  localparam logic [7:0] ByteSlash     = 8'h2F;
  localparam logic [7:0] ByteDot       = 8'h2E;
  localparam logic [7:0] ByteBackslash = 8'h5C;
  localparam logic [7:0] ByteColon     = 8'h3A;
  localparam logic [7:0] ByteTerm      = 8'h00;
  localparam logic [7:0] CtrlLimit     = 8'h20;

  // UTF-8 class masks and their match patterns.
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContCode   = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Code  = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Code  = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Code  = 8'hF0;

  // Held byte from the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] char_byte;
  } rpv_byte_t;

  // Verdict handed from the scanner to the output register.
  typedef struct packed {
    logic valid;
    logic path_ok;
  } rpv_verdict_t;

endpackage

>>> rtl/core/rpv_byte_if.sv
interface rpv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

>>> rtl/core/rpv_verdict_if.sv
interface rpv_verdict_if;
  logic valid;
  logic ready;
  logic path_ok;

  modport source (output valid, output path_ok, input ready);
  modport sink (input valid, input path_ok, output ready);
endinterface

>>> rtl/core/relative_path_validator.sv
// Channel    Dir  Payload         Transaction
// byte_i     in   char_byte[7:0]  one path byte; zero ends the path
// verdict_o  out  path_ok         one verdict per terminating zero byte
//
// One byte is taken per cycle unless a terminator waits for the output register.
// A byte waits in the input register and updates the path state as it leaves;
// a terminator's verdict is loaded into the output register at that same edge.
// Reset clears the path state and both valid flags.
// A stalled verdict keeps the next terminator in the input register, and the
// bytes behind it wait until the output register frees.
module relative_path_validator
  import rpv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rpv_byte_if.sink     byte_i,
  rpv_verdict_if.source verdict_o
);

  rpv_byte_t    held;
  rpv_verdict_t verdict;
  logic         advance;
  logic         out_free;

  rpv_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (byte_i.valid),
    .char_byte_i (byte_i.char_byte),
    .ready_o     (byte_i.ready),
    .advance_i   (advance),
    .held_o      (held)
  );

  rpv_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .held_i     (held),
    .out_free_i (out_free),
    .advance_o  (advance),
    .verdict_o  (verdict)
  );

  rpv_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .verdict_i (verdict),
    .free_o    (out_free),
    .valid_o   (verdict_o.valid),
    .path_ok_o (verdict_o.path_ok),
    .ready_i   (verdict_o.ready)
  );

endmodule

>>> rtl/core/rpv_in_reg.sv
module rpv_in_reg
  import rpv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] char_byte_i,
  output logic       ready_o,
  input  logic       advance_i,
  output rpv_byte_t  held_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // The register takes a new transaction when empty or when its byte moves on.
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= char_byte_i;
    end
  end

  assign held_o = '{valid: valid_q, char_byte: byte_q};

endmodule

>>> rtl/core/rpv_scan.sv
module rpv_scan
  import rpv_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rpv_byte_t    held_i,
  input  logic         out_free_i,
  output logic         advance_o,
  output rpv_verdict_t verdict_o
);

  logic       rej_q, rej_d;
  logic [1:0] pend_q, pend_d;
  logic [1:0] len_q, len_d;
  logic       dots_q, dots_d;

  logic       is_term;
  logic       bad;
  logic [1:0] pend_n;
  logic [1:0] len_n;
  logic       dots_n;
  logic [7:0] b;

  assign b       = held_i.char_byte;
  assign is_term = (b == ByteTerm);

  // A path byte always moves on; a terminator waits for a free output slot.
  assign advance_o = held_i.valid && (!is_term || out_free_i);

  // Verdict from the state left by the bytes before the terminator.
  assign verdict_o.valid   = advance_o && is_term;
  assign verdict_o.path_ok = !rej_q && (len_q != 2'd0) && !((len_q == 2'd2) && dots_q)
                             && (pend_q == 2'd0);

  // Rule checks and state update for one path byte.
  always_comb begin
    bad    = (b == ByteBackslash) || (b == ByteColon) || (b < CtrlLimit);
    pend_n = pend_q;
    len_n  = len_q;
    dots_n = dots_q;

    if (pend_q != 2'd0) begin
      if ((b & ContMask) != ContCode) begin
        bad = 1'b1;
      end else begin
        pend_n = pend_q - 2'd1;
      end
    end else if (b[7]) begin
      if ((b & Lead2Mask) == Lead2Code) begin
        pend_n = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        pend_n = 2'd2;
      end else if ((b & Lead4Mask) == Lead4Code) begin
        pend_n = 2'd3;
      end else begin
        bad = 1'b1;
      end
    end

    if (b == ByteSlash) begin
      if ((len_q == 2'd0) || ((len_q == 2'd2) && dots_q)) begin
        bad = 1'b1;
      end else begin
        len_n  = 2'd0;
        dots_n = 1'b1;
      end
    end else begin
      if (len_q != 2'd3) begin
        len_n = len_q + 2'd1;
      end
      if (b != ByteDot) begin
        dots_n = 1'b0;
      end
    end
  end

  // Next state: clear on a terminator, hold once rejected, reject on a bad byte, else step.
  always_comb begin
    rej_d  = rej_q;
    pend_d = pend_q;
    len_d  = len_q;
    dots_d = dots_q;
    if (advance_o) begin
      if (is_term) begin
        rej_d  = 1'b0;
        pend_d = 2'd0;
        len_d  = 2'd0;
        dots_d = 1'b1;
      end else if (!rej_q) begin
        if (bad) begin
          rej_d = 1'b1;
        end else begin
          pend_d = pend_n;
          len_d  = len_n;
          dots_d = dots_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rej_q  <= 1'b0;
      pend_q <= 2'd0;
      len_q  <= 2'd0;
      dots_q <= 1'b1;
    end else begin
      rej_q  <= rej_d;
      pend_q <= pend_d;
      len_q  <= len_d;
      dots_q <= dots_d;
    end
  end

endmodule

>>> rtl/core/rpv_out_reg.sv
module rpv_out_reg
  import rpv_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rpv_verdict_t verdict_i,
  output logic         free_o,
  output logic         valid_o,
  output logic         path_ok_o,
  input  logic         ready_i
);

  logic valid_q;
  logic ok_q;

  // The slot can load when empty or when its transaction leaves this cycle.
  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (verdict_i.valid) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (verdict_i.valid) begin
      ok_q <= verdict_i.path_ok;
    end
  end

  assign valid_o   = valid_q;
  assign path_ok_o = ok_q;

endmodule
